// ----- rtl/core/skac_pkg.sv -----
// Shared types, constants and table builders for the soft-knee compressor.
package skac_pkg;

  localparam int LogTableBitsDef = 10;
  localparam int ExpTableBitsDef = 10;
  localparam int SampleW         = 24;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 24;

  localparam logic signed [15:0] FloorDb     = -16'sd30720;
  localparam logic [24:0]        FloorMag    = 25'd17;
  localparam logic [18:0]        DbPerOctave = 19'd394566;
  localparam logic [21:0]        OctPerDb    = 22'd2786635;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_KNEE_W    = 3'd1,
    CFG_KNEE_RCP  = 3'd2,
    CFG_INV_RATIO = 3'd3,
    CFG_MAKEUP    = 3'd4,
    CFG_ATTACK    = 3'd5,
    CFG_RELEASE   = 3'd6
  } cfg_idx_e;

  // one classified sample pair as it sits in the queue
  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      bypass;
    logic                      quiet;
    logic [24:0]               mag;
    logic [4:0]                lead;
  } skac_item_t;

  // log2(1+i/2^bits) in Q.16, by repeated squaring
  function automatic logic [16:0] log_entry(int bits, int i);
    logic [63:0] x;
    logic [63:0] r;
    x = (64'(1 << bits) + 64'(i)) << (30 - bits);
    r = '0;
    for (int k = 0; k < 18; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= 64'h8000_0000) begin
        r = r | 64'd1;
        x = x >> 1;
      end
    end
    return 17'((r + 64'd2) >> 2);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] res;
    logic [63:0] bt;
    vv  = v;
    res = '0;
    bt  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (vv >= res + bt) begin
        vv  = vv - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(i/2^bits) in Q.30 from a product of square roots of two
  function automatic logic [31:0] exp_entry(int bits, int i);
    logic [63:0] root [14];
    logic [63:0] acc;
    for (int k = 0; k < 14; k++) root[k] = '0;
    root[0] = isqrt64(64'd2 << 60);
    for (int k = 1; k < bits; k++) root[k] = isqrt64(root[k-1] << 30);
    acc = 64'd1 << 30;
    for (int k = 0; k < bits; k++) begin
      if (((i >> (bits - 1 - k)) & 1) != 0) begin
        acc = (acc * root[k] + (64'd1 << 29)) >> 30;
      end
    end
    return 32'(acc);
  endfunction

  // shift right with rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  // scale a sample by tab * 2^(n-30), saturating
  function automatic logic signed [SampleW-1:0] apply_gain(logic signed [SampleW-1:0] x,
                                                          logic [31:0] tab,
                                                          logic signed [15:0] n);
    logic [63:0]        mag;
    logic [63:0]        r;
    logic signed [31:0] sh;
    logic [5:0]         sa;
    mag = 64'(x < 0 ? -25'(x) : 25'(x)) * 64'(tab);
    sh  = 32'sd30 - 32'(n);
    sa  = 6'(sh);
    if (sh >= 32'sd64) r = '0;
    else if (sh > 0) r = (mag + (64'd1 << (sa - 6'd1))) >> sa;
    else if (sh == 0) r = mag;
    else if (mag == 0) r = '0;
    else if (-sh >= 32'sd9) r = 64'd1 << 40;
    else r = mag << 6'(-sh);
    if (r > (64'd1 << 40)) r = 64'd1 << 40;
    return sat24(x < 0 ? -$signed(r) : $signed(r));
  endfunction

endpackage

// ----- rtl/core/skac_front.sv -----
// Input side: accept a sample pair, classify it and queue it for the back end.
module skac_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [47:0]               in_data_i,
  input  logic signed [15:0]        threshold_i,
  input  logic signed [15:0]        makeup_i,
  output logic                      q_valid_o,
  output skac_pkg::skac_item_t      q_item_o,
  input  logic                      q_pop_i
);
  import skac_pkg::*;

  skac_item_t          mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  skac_item_t          item;
  logic signed [24:0]  sum;
  logic                push;

  always_comb begin
    item.left   = in_data_i[23:0];
    item.right  = in_data_i[47:24];
    item.bypass = (threshold_i >= 0) && (makeup_i == 16'sd0);
    sum         = 25'(item.left) + 25'(item.right);
    item.mag    = sum < 0 ? -sum : sum;
    item.quiet  = item.mag < FloorMag;
    item.lead   = '0;
    for (int b = 0; b < 25; b++) begin
      if (item.mag[b]) item.lead = 5'(b);
    end
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ----- rtl/core/skac_back.sv -----
// Back end: level detection, gain computer, smoother and gain stage as a sequencer.
module skac_back #(
  parameter int LOG_TABLE_BITS = skac_pkg::LogTableBitsDef,
  parameter int EXP_TABLE_BITS = skac_pkg::ExpTableBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  skac_pkg::skac_item_t      q_item_i,
  output logic                      q_pop_o,
  output logic                      raise_o,
  input  logic signed [15:0]        threshold_i,
  input  logic [13:0]               knee_w_i,
  input  logic [23:0]               knee_rcp_i,
  input  logic [16:0]               inv_ratio_i,
  input  logic signed [15:0]        makeup_i,
  input  logic [15:0]               attack_i,
  input  logic [15:0]               release_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [47:0]               out_data_o
);
  import skac_pkg::*;

  localparam int LogN = 1 << LOG_TABLE_BITS;
  localparam int ExpN = 1 << EXP_TABLE_BITS;

  typedef logic [16:0] log_rom_t [LogN];
  typedef logic [31:0] exp_rom_t [ExpN];

  function automatic log_rom_t build_log();
    log_rom_t t;
    for (int i = 0; i < LogN; i++) t[i] = log_entry(LOG_TABLE_BITS, i);
    return t;
  endfunction

  function automatic exp_rom_t build_exp();
    exp_rom_t t;
    for (int i = 0; i < ExpN; i++) t[i] = exp_entry(EXP_TABLE_BITS, i);
    return t;
  endfunction

  localparam log_rom_t LogRom = build_log();
  localparam exp_rom_t ExpRom = build_exp();

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_LOOK  = 13'b0000000000010,
    ST_DB    = 13'b0000000000100,
    ST_KNEE1 = 13'b0000000001000,
    ST_KNEE2 = 13'b0000000010000,
    ST_KNEE3 = 13'b0000000100000,
    ST_SM1   = 13'b0000001000000,
    ST_SM2   = 13'b0000010000000,
    ST_GAIN  = 13'b0000100000000,
    ST_EXP   = 13'b0001000000000,
    ST_APPL  = 13'b0010000000000,
    ST_APPR  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_e;

  state_e                  state_q, state_d;
  skac_item_t              item_q;
  logic [16:0]             log_q;
  logic signed [15:0]      xg_q;
  logic signed [17:0]      ov_q;
  logic                    knee_q, above_q;
  logic [29:0]             sq_q;
  logic signed [47:0]      prod_q;
  logic signed [31:0]      xl_q;
  logic signed [50:0]      sm_q;
  logic signed [23:0]      prev_q;
  logic signed [31:0]      ex_q;
  logic [31:0]             exp_q;
  logic signed [23:0]      res_l_q, res_r_q;
  logic                    out_valid_q;
  logic [47:0]             out_data_q;

  logic [LOG_TABLE_BITS-1:0] log_idx;
  logic [EXP_TABLE_BITS-1:0] exp_idx;
  logic [63:0]               idx_tmp;
  logic [20:0]               negd;
  logic [39:0]               db_prod;
  logic signed [15:0]        xg_c;
  logic signed [17:0]        ov_c;
  logic signed [18:0]        ov2;
  logic [18:0]               abs2;
  logic                      in_knee, above;
  logic [15:0]               s_c;
  logic signed [31:0]        xl_c;
  logic [15:0]               a_c;
  logic [15:0]               rel_eff;
  logic signed [63:0]        sm_c;
  logic signed [23:0]        y_c;
  logic signed [24:0]        g_c;
  logic signed [31:0]        ex_c;
  logic signed [15:0]        n_c;
  logic                      load_out;

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign raise_o = q_pop_o && !q_item_i.bypass;
  assign rel_eff = (release_i < attack_i) ? attack_i : release_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (32'(item_q.lead) >= LOG_TABLE_BITS) begin
      idx_tmp = 64'(item_q.mag) >> (32'(item_q.lead) - LOG_TABLE_BITS);
    end else begin
      idx_tmp = 64'(item_q.mag) << (LOG_TABLE_BITS - 32'(item_q.lead));
    end
    log_idx = idx_tmp[LOG_TABLE_BITS-1:0];

    negd    = 21'(24 << 16) - (21'({item_q.lead, 16'b0}) + 21'(log_q));
    db_prod = 40'(negd) * 40'(DbPerOctave);
    xg_c    = item_q.quiet ? FloorDb : -16'((db_prod + 40'd8388608) >> 24);

    ov_c    = 18'(xg_q) - 18'(threshold_i);
    ov2     = 19'(ov_c) <<< 1;
    abs2    = ov2 < 0 ? 19'(-ov2) : 19'(ov2);
    in_knee = abs2 <= 19'(knee_w_i);
    above   = !in_knee && (ov2 > $signed(19'(knee_w_i)));
    s_c     = 16'(ov2 + $signed(19'(knee_w_i)));

    if (knee_q) begin
      xl_c = 32'(-rnd_shr(64'(prod_q) * (64'(inv_ratio_i) - 64'sd65536), 18));
    end else if (above_q) begin
      xl_c = 32'(ov_q) - 32'(rnd_shr(64'(prod_q), 16));
    end else begin
      xl_c = '0;
    end

    a_c  = (xl_q > 32'(prev_q)) ? attack_i : rel_eff;
    sm_c = 64'($signed({1'b0, a_c})) * (64'(prev_q) - 64'(xl_q));
    y_c  = sat24(rnd_shr((64'(xl_q) <<< 16) + 64'(sm_q), 16));

    g_c  = 25'(makeup_i) - 25'(prev_q);
    ex_c = 32'(rnd_shr(64'(g_c) * 64'(OctPerDb), 16));
    n_c  = 16'(ex_q >>> 16);
    exp_idx = ex_q[15 -: EXP_TABLE_BITS];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = q_item_i.bypass ? ST_DONE : ST_LOOK;
      ST_LOOK:  state_d = ST_DB;
      ST_DB:    state_d = ST_KNEE1;
      ST_KNEE1: state_d = ST_KNEE2;
      ST_KNEE2: state_d = ST_KNEE3;
      ST_KNEE3: state_d = ST_SM1;
      ST_SM1:   state_d = ST_SM2;
      ST_SM2:   state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_EXP;
      ST_EXP:   state_d = ST_APPL;
      ST_APPL:  state_d = ST_APPR;
      ST_APPR:  state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath registers, one step per state
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q  <= q_item_i;
      res_l_q <= q_item_i.left;
      res_r_q <= q_item_i.right;
    end
    if (state_q == ST_LOOK) log_q <= LogRom[log_idx];
    if (state_q == ST_DB) xg_q <= xg_c;
    if (state_q == ST_KNEE1) begin
      ov_q    <= ov_c;
      knee_q  <= in_knee;
      above_q <= above;
      sq_q    <= 30'(32'(s_c) * 32'(s_c));
    end
    if (state_q == ST_KNEE2) begin
      if (knee_q) prod_q <= 48'((64'(sq_q) * 64'(knee_rcp_i)) >> 24);
      else prod_q <= 48'(64'(ov_q) * 64'(inv_ratio_i));
    end
    if (state_q == ST_KNEE3) xl_q <= xl_c;
    if (state_q == ST_SM1) sm_q <= 51'(sm_c);
    if (state_q == ST_GAIN) ex_q <= ex_c;
    if (state_q == ST_EXP) exp_q <= ExpRom[exp_idx];
    if (state_q == ST_APPL) res_l_q <= apply_gain(item_q.left, exp_q, n_c);
    if (state_q == ST_APPR) res_r_q <= apply_gain(item_q.right, exp_q, n_c);
    if (load_out) out_data_q <= {res_r_q, res_l_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SM2) prev_q <= y_c;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/soft_knee_audio_compressor.sv -----
// Top level of the soft-knee stereo compressor: config registers, front, back.
//
//  channel   dir  handshake               payload (low bit first)
//  s_axis    in   tvalid/tready           tdata: left_sample[23:0], right_sample[47:24]
//  m_axis    out  tvalid/tready           tdata: left_out[23:0], right_out[47:24]
//  cfg       in   cfg_we_i (no wait)      cfg_idx_i selects register, cfg_data_i value
//
// A compressed pair steps through the back-end sequencer (at most one multiply per step)
// and then the output register; a bypassed pair goes from IDLE straight to DONE.
// The two-entry queue keeps accepting while the sequencer or the output stalls, until it is full.
// Reset clears the smoothed reduction and loads the register defaults.
// An output transfer held back stalls the sequencer in its final step only.
module soft_knee_audio_compressor #(
  parameter int LOG_TABLE_BITS = skac_pkg::LogTableBitsDef,
  parameter int EXP_TABLE_BITS = skac_pkg::ExpTableBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,   // left_sample, right_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,   // left_out, right_out
  input  logic                          cfg_we_i,
  input  logic [skac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [skac_pkg::CfgDataW-1:0] cfg_data_i
);
  import skac_pkg::*;

  logic signed [15:0] threshold_q;
  logic [13:0]        knee_w_q;
  logic [23:0]        knee_rcp_q;
  logic [16:0]        inv_ratio_q;
  logic signed [15:0] makeup_q;
  logic [15:0]        attack_q;
  logic [15:0]        release_q;

  logic       q_valid, q_pop, raise;
  skac_item_t q_item;

  // configuration writes; a write past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      knee_w_q    <= 14'd26;
      knee_rcp_q  <= 24'd13107;
      inv_ratio_q <= 17'd65536;
      makeup_q    <= '0;
      attack_q    <= '0;
      release_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD: threshold_q <= cfg_data_i[15:0];
          CFG_KNEE_W:    knee_w_q    <= cfg_data_i[13:0];
          CFG_KNEE_RCP:  knee_rcp_q  <= cfg_data_i[23:0];
          CFG_INV_RATIO: inv_ratio_q <= cfg_data_i[16:0];
          CFG_MAKEUP:    makeup_q    <= cfg_data_i[15:0];
          CFG_ATTACK:    attack_q    <= cfg_data_i[15:0];
          CFG_RELEASE:   release_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end else if (raise && (release_q < attack_q)) begin
        // raise release to attack when a compressed pair starts and no config write lands
        release_q <= attack_q;
      end
    end
  end

  skac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .threshold_i (threshold_q),
    .makeup_i    (makeup_q),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  skac_back #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .raise_o     (raise),
    .threshold_i (threshold_q),
    .knee_w_i    (knee_w_q),
    .knee_rcp_i  (knee_rcp_q),
    .inv_ratio_i (inv_ratio_q),
    .makeup_i    (makeup_q),
    .attack_i    (attack_q),
    .release_i   (release_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // release never trails attack after a compressed pair starts without a config write
  a_release_raised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raise && !cfg_we_i |=> release_q >= attack_q)
    else $error("release coefficient below attack after raise");

  // a compressed pair occupies the sequencer, so no second pair is popped right behind it
  a_raise_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raise |=> !raise && !q_pop)
    else $error("sequencer took a second pair too early");

  // the queue is only drained when it holds something
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ----- tb/soft_knee_audio_compressor_tb.sv -----
// Self-checking testbench for the soft-knee stereo compressor.
`timescale 1ns / 1ps

module soft_knee_audio_compressor_tb;
  import skac_pkg::*;

  localparam int LogBits = 10;
  localparam int ExpBits = 10;
  localparam int LogN    = 1 << LogBits;
  localparam int ExpN    = 1 << ExpBits;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // left_sample, right_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // left_out, right_out
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  soft_knee_audio_compressor dut (.*);

  always #10 clk_i = ~clk_i;

  // Gain tables, built independently from the same math.
  longint unsigned log2_frac [LogN];
  longint unsigned pow2_frac [ExpN];

  // Predictor's copy of the registers and the smoother state.
  longint thr_db, mk_db, sm_red;
  longint unsigned kw_db, k_rcp, inv_rat, atk, rel;

  // Expected output pairs, oldest first.
  logic [47:0] pending_out [$];
  int errors = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void fill_tables();
    longint unsigned x, r, acc;
    longint unsigned roots [ExpBits];
    for (int i = 0; i < LogN; i++) begin
      x = (longint'(LogN) + i) << (30 - LogBits);
      r = 0;
      for (int k = 0; k < 18; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      log2_frac[i] = (r + 2) >> 2;
    end
    roots[0] = int_sqrt(64'd2 << 60);
    for (int k = 1; k < ExpBits; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    for (int i = 0; i < ExpN; i++) begin
      acc = 64'd1 << 30;
      for (int k = 0; k < ExpBits; k++)
        if ((i >> (ExpBits - 1 - k)) & 1) acc = (acc * roots[k] + (64'd1 << 29)) >> 30;
      pow2_frac[i] = acc;
    end
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint scale_sample(longint x, longint unsigned tab, longint n);
    longint unsigned m, r;
    longint sh;
    m = longint'(x < 0 ? -x : x) * tab;
    sh = 30 - n;
    if (sh >= 64) r = 0;
    else if (sh > 0) r = (m + (64'd1 << (sh - 1))) >> sh;
    else if (sh == 0) r = m;
    else if (m == 0) r = 0;
    else if (-sh >= 9) r = 64'd1 << 40;
    else r = m << (-sh);
    if (r > (64'd1 << 40)) r = 64'd1 << 40;
    return clip24(x < 0 ? -longint'(r) : longint'(r));
  endfunction

  function automatic void set_shadow(cfg_idx_e idx, logic [23:0] v);
    case (idx)
      CFG_THRESHOLD: thr_db = longint'($signed(v[15:0]));
      CFG_KNEE_W:    kw_db = v[13:0];
      CFG_KNEE_RCP:  k_rcp = v;
      CFG_INV_RATIO: inv_rat = v[16:0];
      CFG_MAKEUP:    mk_db = longint'($signed(v[15:0]));
      CFG_ATTACK:    atk = v[15:0];
      CFG_RELEASE:   rel = v[15:0];
      default: ;
    endcase
  endfunction

  // Run one pair through the gain computer and smoother; return the output pair (a bypassed pair comes back unchanged).
  function automatic logic [47:0] compress_pair(logic [47:0] din);
    longint l, r, s, xg, ov, yg, xl, a, y, g, ex, n, f, t, e;
    longint unsigned mg, idx, l2, sq;
    logic [23:0] lo, ro;
    l = longint'($signed(din[23:0]));
    r = longint'($signed(din[47:24]));
    if (thr_db >= 0 && mk_db == 0) return din;
    if (rel < atk) rel = atk;
    s = l + r;
    mg = s < 0 ? -s : s;
    if (mg < 17) begin
      xg = -30720;
    end else begin
      e = 0;
      while ((mg >> (e + 1)) != 0) e++;
      if (e >= LogBits) idx = (mg >> (e - LogBits)) & (LogN - 1);
      else idx = (mg << (LogBits - e)) & (LogN - 1);
      l2 = (longint'(e) << 16) + log2_frac[idx];
      xg = -longint'((((64'd24 << 16) - l2) * 394566 + (64'd1 << 23)) >> 24);
    end
    ov = xg - thr_db;
    if (2 * (ov < 0 ? -ov : ov) <= longint'(kw_db)) begin
      sq = 2 * ov + longint'(kw_db);
      t = longint'((sq * sq * k_rcp) >> 24);
      yg = xg + round_shift(t * (longint'(inv_rat) - 65536), 18);
    end else if (2 * ov > longint'(kw_db)) begin
      yg = thr_db + round_shift(ov * longint'(inv_rat), 16);
    end else begin
      yg = xg;
    end
    xl = xg - yg;
    a = xl > sm_red ? atk : rel;
    y = clip24(round_shift(a * sm_red + (65536 - a) * xl, 16));
    sm_red = y;
    g = mk_db - y;
    ex = round_shift(g * 2786635, 16);
    n = ex >= 0 ? (ex >>> 16) : -((-ex + 65535) >>> 16);
    f = ex - n * 65536;
    lo = 24'(scale_sample(l, pow2_frac[(f >> (16 - ExpBits)) & (ExpN - 1)], n));
    ro = 24'(scale_sample(r, pow2_frac[(f >> (16 - ExpBits)) & (ExpN - 1)], n));
    return {ro, lo};
  endfunction

  // Write one register through the config port, keeping the shadow in step.
  task automatic write_reg(cfg_idx_e idx, logic [23:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_shadow(idx, v);
  endtask

  // Wait until every expected pair has come out, then let the pipe drain.
  task automatic drain_block();
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Offer one pair and hold it until the block takes it.
  task automatic send_pair(logic [47:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_out.push_back(compress_pair(d));
  endtask

  task automatic send_random(int count, int bias);
    logic [47:0] d;
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < count; k++) begin
        d = {$urandom, $urandom};
        // mostly audio-like levels so the knee and smoother get exercised
        if (bias && $urandom_range(0, 3) != 0) begin
          d[23:0]  = 24'($signed(d[23:0]) >>> $urandom_range(0, 20));
          d[47:24] = $urandom_range(0, 1) ? d[23:0] + 24'($urandom_range(0, 255)) :
                     24'($signed(d[47:24]) >>> $urandom_range(0, 20));
        end
        send_pair(d);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver stalls in its own pattern: long ready runs mixed with stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                          ($time / 20000) % 3 == 0;
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: output expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata[23:0] !== pending_out[0][23:0]) begin
          $display("%0t: left_out expected %h actual %h", $time,
                   pending_out[0][23:0], m_axis_tdata[23:0]);
          errors++;
        end
        if (m_axis_tdata[47:24] !== pending_out[0][47:24]) begin
          $display("%0t: right_out expected %h actual %h", $time,
                   pending_out[0][47:24], m_axis_tdata[47:24]);
          errors++;
        end
        void'(pending_out.pop_front());
      end
    end
  end

  // Directed rows: input pair and, where known at a glance, the output.
  typedef struct {
    logic [47:0] din;
    bit          known;
    logic [47:0] dout;
  } pair_row_t;

  pair_row_t bypass_rows [6] = '{
    '{48'h7FFFFF_7FFFFF, 1, 48'h7FFFFF_7FFFFF},
    '{48'h800000_800000, 1, 48'h800000_800000},
    '{48'h7FFFFF_800000, 1, 48'h7FFFFF_800000},
    '{48'h000000_000000, 1, 48'h000000_000000},
    '{48'hFFFFFF_000001, 1, 48'hFFFFFF_000001},
    '{48'h123456_ABCDEF, 1, 48'h123456_ABCDEF}
  };
  pair_row_t comp_rows [10] = '{
    '{48'h7FFFFF_7FFFFF, 0, '0},
    '{48'h800000_800000, 0, '0},
    '{48'h7FFFFF_800000, 0, '0},
    '{48'h000000_000000, 1, 48'h000000_000000},
    '{48'h000008_000008, 0, '0},
    '{48'h000009_000008, 0, '0},
    '{48'h400000_400000, 0, '0},
    '{48'h001000_001000, 0, '0},
    '{48'hC00000_C00000, 0, '0},
    '{48'h000100_FFFF00, 0, '0}
  };

  task automatic run_rows(pair_row_t rows [], bit check_known);
    foreach (rows[i]) begin
      send_pair(rows[i].din);
      if (check_known && rows[i].known && pending_out[$] !== rows[i].dout) begin
        $display("%0t: row %0d expected %h actual %h", $time, i,
                 rows[i].dout, pending_out[$]);
        errors++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    fill_tables();
    thr_db = 0; kw_db = 26; k_rcp = 13107; inv_rat = 65536;
    mk_db = 0; atk = 0; rel = 0; sm_red = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults pass the samples through.
    run_rows(bypass_rows, 1);
    drain_block();

    // Hard compression, huge makeup, release below attack.
    write_reg(CFG_THRESHOLD, 24'(-16'sd30720));
    write_reg(CFG_KNEE_W, 24'd0);
    write_reg(CFG_KNEE_RCP, 24'hFFFFFF);
    write_reg(CFG_INV_RATIO, 24'd0);
    write_reg(CFG_MAKEUP, 24'(16'sd30720));
    write_reg(CFG_ATTACK, 24'd65535);
    write_reg(CFG_RELEASE, 24'd0);
    run_rows(comp_rows, 1);
    drain_block();

    // Soft knee, tiny makeup, fast smoothing.
    write_reg(CFG_THRESHOLD, 24'(-16'sd5120));
    write_reg(CFG_KNEE_W, 24'd10240);
    write_reg(CFG_KNEE_RCP, 24'd819);
    write_reg(CFG_INV_RATIO, 24'd16384);
    write_reg(CFG_MAKEUP, 24'(-16'sd30720));
    write_reg(CFG_ATTACK, 24'd0);
    write_reg(CFG_RELEASE, 24'd0);
    run_rows(comp_rows, 0);
    send_random(300, 1);
    drain_block();

    // Random register settings, well-formed musical knees mostly.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_THRESHOLD, 24'(-$signed(16'($urandom_range(0, 30720)))));
      write_reg(CFG_KNEE_W, 24'($urandom_range(0, 16383)));
      write_reg(CFG_KNEE_RCP, ph == 5 ? 24'($urandom) : 24'($urandom_range(0, 65535)));
      write_reg(CFG_INV_RATIO, ph == 4 ? 24'($urandom_range(65537, 131071)) :
                               24'($urandom_range(0, 65536)));
      write_reg(CFG_MAKEUP, 24'($signed(16'($urandom_range(0, 65535)))));
      write_reg(CFG_ATTACK, 24'($urandom_range(0, 65535)));
      write_reg(CFG_RELEASE, 24'($urandom_range(0, 65535)));
      send_random(270, 1);
      drain_block();
    end

    // Back to bypass with threshold at its upper end.
    write_reg(CFG_THRESHOLD, 24'd0);
    write_reg(CFG_MAKEUP, 24'd0);
    send_random(20, 0);
    drain_block();

    if (errors == 0 && pending_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
